// File: hw/rtl/sbeq_pkg.sv
// Shared constants, types and saturation helpers for the stereo biquad equaliser
`timescale 1ns / 1ps
package sbeq_pkg;

    localparam int NUM_BANDS   = 10;
    localparam int NUM_FILTERS = 2 * NUM_BANDS + 1;
    localparam int NUM_COEFS   = 5;
    localparam int COEF_DEPTH  = NUM_FILTERS * NUM_COEFS;
    localparam int DLY_DEPTH   = NUM_FILTERS * 4;
    localparam int CAW         = $clog2(COEF_DEPTH);
    localparam int DAW         = $clog2(DLY_DEPTH);
    localparam int FW          = $clog2(NUM_FILTERS);
    localparam int BCW         = $clog2(NUM_BANDS + 1);
    localparam int BIW         = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_COEF   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [2:0] K_B0 = 3'd0;
    localparam logic [2:0] K_B1 = 3'd1;
    localparam logic [2:0] K_B2 = 3'd2;
    localparam logic [2:0] K_A1 = 3'd3;
    localparam logic [2:0] K_A2 = 3'd4;

    localparam logic [15:0]        GAIN_RESET = 16'd4096;
    localparam logic signed [31:0] ONE_Q428   = 32'sd268435456;

    typedef struct packed {
        logic                    en;
        logic [CAW-1:0]          addr;
        logic signed [31:0]      data;
    } t_coef_wr;

    typedef struct packed {
        logic [CAW-1:0] addr;
        logic           is_b0;
    } t_coef_rd;

    typedef struct packed {
        logic               en;
        logic [DAW-1:0]     addr;
        logic signed [39:0] data;
    } t_dly_wr;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        if (v > 52'sd2147483647) r = 32'sh7FFF_FFFF;
        else if (v < -52'sd2147483648) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [45:0] v);
        logic signed [39:0] r;
        if (v > 46'sh7F_FFFF_FFFF) r = 40'sh7F_FFFF_FFFF;
        else if (v < -46'sh80_0000_0000) r = 40'sh80_0000_0000;
        else r = v[39:0];
        return r;
    endfunction

    function automatic logic signed [23:0] clamp24(input logic signed [31:0] v);
        logic signed [23:0] r;
        if (v > 32'sd8388607) r = 24'sh7F_FFFF;
        else if (v < -32'sd8388608) r = 24'sh80_0000;
        else r = v[23:0];
        return r;
    endfunction

    function automatic logic [30:0] mag31(input logic signed [31:0] v);
        logic [31:0] a;
        logic [30:0] r;
        a = v[31] ? 32'(-v) : 32'(v);
        r = a[31] ? 31'h7FFF_FFFF : a[30:0];
        return r;
    endfunction

endpackage

// File: hw/rtl/sbeq_coef_store.sv
// Coefficient memory with per-entry valid bits; unwritten entries read as pass-through
`timescale 1ns / 1ps
module sbeq_coef_store import sbeq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_coef_wr            i_wr,
    input  t_coef_rd            i_rd,
    output logic signed [31:0]  o_rd_data
);

    logic signed [31:0]    r_mem [COEF_DEPTH];
    logic [COEF_DEPTH-1:0] r_valid;
    logic signed [31:0]    r_rd_data;
    logic                  r_rd_ok;
    logic                  r_rd_b0;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd.addr];
        r_rd_b0   <= i_rd.is_b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_rd_ok <= r_valid[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : (r_rd_b0 ? ONE_Q428 : 32'sd0);

endmodule

// File: hw/rtl/sbeq_dly_store.sv
// Filter delay memory with per-entry valid bits and a clear that empties all entries at once
`timescale 1ns / 1ps
module sbeq_dly_store import sbeq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clear,
    input  t_dly_wr             i_wr,
    input  logic [DAW-1:0]      i_rd_addr,
    output logic signed [39:0]  o_rd_data
);

    logic signed [39:0]   r_mem [DLY_DEPTH];
    logic [DLY_DEPTH-1:0] r_valid;
    logic signed [39:0]   r_rd_data;
    logic                 r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_rd_ok <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : 40'sd0;

endmodule

// File: hw/rtl/stereo_biquad_eq_with_band_meters_top.sv
// Stereo biquad equaliser with band meters: sequencer and shared multiplier
// Sample word: gain states G0-G2, then states B0-B6 for each of 42 biquads, then the pair.
// Busy until the last output word is accepted; every product uses the one 32x32 multiplier.
// End of block adds one report word per band, one per accepted output.
// Coefficient and clear words give no output and leave the sequencer idle.
// Synchronous active-low reset: gain to unity, coefficients pass-through, delays and peaks zero.
`timescale 1ns / 1ps
module stereo_biquad_eq_with_band_meters_top import sbeq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_opcode,
    input  logic signed [23:0] i_left_in,
    input  logic signed [23:0] i_right_in,
    input  logic               i_end_of_block,
    input  logic [4:0]         i_filter_select,
    input  logic [2:0]         i_coef_select,
    input  logic signed [31:0] i_coef_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_kind,
    output logic signed [23:0] o_left_out,
    output logic signed [23:0] o_right_out,
    output logic [3:0]         o_band_index,
    output logic [30:0]        o_band_level,
    output logic               o_last
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_G0, ST_G1, ST_G2,
        ST_B0, ST_B1, ST_B2, ST_B3, ST_B4, ST_B5, ST_B6,
        ST_OUT
    } t_state;

    t_state             r_state;
    logic [15:0]        r_gain;
    logic signed [23:0] r_inl;
    logic signed [23:0] r_inr;
    logic               r_eob;
    logic signed [31:0] r_l, r_r, r_dl, r_dr, r_y;
    logic [30:0]        r_ml;
    logic signed [63:0] r_prod;
    logic signed [39:0] r_z;
    logic signed [45:0] r_acc;
    logic [BCW-1:0]     r_band;
    logic               r_ana;
    logic               r_ch;
    logic               r_rep_pend;
    logic [30:0]        r_peak [NUM_BANDS];

    logic               r_ovalid, r_okind, r_olast;
    logic signed [23:0] r_oleft, r_oright;
    logic [3:0]         r_oband;
    logic [30:0]        r_olevel;

    logic [FW-1:0]      filt;
    logic [2:0]         k_sel;
    logic               z_sel;
    logic signed [31:0] mul_a, mul_b, x_cur;
    logic signed [63:0] prod;
    logic signed [43:0] p20;
    logic signed [45:0] t_y;
    logic signed [63:0] t_g;
    logic signed [31:0] y_new, g_new;
    logic signed [31:0] cdata;
    logic signed [39:0] zdata;
    logic [30:0]        m_y, m_max;
    logic               final_f, last_band, in_acc;
    t_coef_wr           coef_wr;
    t_coef_rd           coef_rd;
    t_dly_wr            dly_wr;
    logic [DAW-1:0]     dly_rd_addr;
    logic               dly_clear;

    assign in_acc    = i_valid && o_ready;
    assign final_f   = (r_band == BCW'(NUM_BANDS));
    assign last_band = (r_band == BCW'(NUM_BANDS - 1));

    always_comb begin
        if (final_f) filt = FW'(2 * NUM_BANDS);
        else if (r_ana) filt = FW'(NUM_BANDS + int'(r_band));
        else filt = FW'(r_band);
    end

    always_comb begin
        case (r_state)
            ST_B0:   k_sel = K_B0;
            ST_B1:   k_sel = K_B1;
            ST_B2:   k_sel = K_A1;
            ST_B3:   k_sel = K_B2;
            ST_B4:   k_sel = K_A2;
            default: k_sel = K_B0;
        endcase
    end

    assign z_sel = (r_state == ST_B0) ? 1'b0 : 1'b1;

    assign coef_rd.addr  = CAW'(int'(filt) * NUM_COEFS + int'(k_sel));
    assign coef_rd.is_b0 = (k_sel == K_B0);
    assign dly_rd_addr   = DAW'(int'(filt) * 4 + int'(r_ch) * 2 + int'(z_sel));

    assign coef_wr.en   = in_acc && (i_opcode == OP_COEF)
                          && (int'(i_filter_select) < NUM_FILTERS)
                          && (int'(i_coef_select) < NUM_COEFS);
    assign coef_wr.addr = CAW'(int'(i_filter_select) * NUM_COEFS + int'(i_coef_select));
    assign coef_wr.data = i_coef_value;
    assign dly_clear    = in_acc && (i_opcode == OP_CLEAR);

    sbeq_coef_store u_coef (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (coef_wr),
        .i_rd      (coef_rd),
        .o_rd_data (cdata)
    );

    sbeq_dly_store u_dly (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (dly_clear),
        .i_wr      (dly_wr),
        .i_rd_addr (dly_rd_addr),
        .o_rd_data (zdata)
    );

    always_comb begin
        if (r_ana) x_cur = r_ch ? r_dr : r_dl;
        else x_cur = r_ch ? r_r : r_l;
    end

    always_comb begin
        case (r_state)
            ST_G0:   begin mul_a = 32'(r_inl); mul_b = $signed({16'd0, r_gain}); end
            ST_G1:   begin mul_a = 32'(r_inr); mul_b = $signed({16'd0, r_gain}); end
            ST_B3,
            ST_B5:   begin mul_a = cdata;      mul_b = r_y;   end
            default: begin mul_a = cdata;      mul_b = x_cur; end
        endcase
    end

    assign prod  = mul_a * mul_b;
    assign p20   = $signed(r_prod[63:20]);
    assign t_y   = 46'(p20) + 46'(r_z) + 46'sd128;
    assign y_new = sat32(52'($signed(t_y[45:8])));
    assign t_g   = r_prod + 64'sd2048;
    assign g_new = sat32($signed(t_g[63:12]));
    assign m_y   = mag31(r_y);
    assign m_max = (r_ml > m_y) ? r_ml : m_y;

    always_comb begin
        dly_wr.en   = 1'b0;
        dly_wr.addr = DAW'(int'(filt) * 4 + int'(r_ch) * 2);
        dly_wr.data = sat40(r_acc - 46'(p20));
        if (r_state == ST_B4) begin
            dly_wr.en = 1'b1;
        end else if (r_state == ST_B6) begin
            dly_wr.en   = 1'b1;
            dly_wr.addr = DAW'(int'(filt) * 4 + int'(r_ch) * 2 + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_gain     <= GAIN_RESET;
            r_ovalid   <= 1'b0;
            r_band     <= '0;
            r_ana      <= 1'b1;
            r_ch       <= 1'b0;
            r_rep_pend <= 1'b0;
            for (int i = 0; i < NUM_BANDS; i++) r_peak[i] <= '0;
        end else begin
            r_prod <= prod;
            if (i_cfg_valid) begin
                r_gain <= i_cfg_data;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && i_opcode == OP_SAMPLE) begin
                        r_inl   <= i_left_in;
                        r_inr   <= i_right_in;
                        r_eob   <= i_end_of_block;
                        r_band  <= '0;
                        r_ana   <= 1'b1;
                        r_ch    <= 1'b0;
                        r_state <= ST_G0;
                    end
                end
                ST_G0: r_state <= ST_G1;
                ST_G1: begin
                    r_l     <= g_new;
                    r_dl    <= g_new;
                    r_state <= ST_G2;
                end
                ST_G2: begin
                    r_r     <= g_new;
                    r_dr    <= g_new;
                    r_state <= ST_B0;
                end
                ST_B0: r_state <= ST_B1;
                ST_B1: begin
                    r_z     <= zdata;
                    r_state <= ST_B2;
                end
                ST_B2: begin
                    r_y     <= y_new;
                    r_z     <= zdata;
                    r_state <= ST_B3;
                end
                ST_B3: begin
                    r_acc   <= 46'(p20) + 46'(r_z);
                    r_state <= ST_B4;
                end
                ST_B4: r_state <= ST_B5;
                ST_B5: begin
                    r_acc   <= 46'(p20);
                    r_state <= ST_B6;
                end
                ST_B6: begin
                    r_state <= ST_B0;
                    if (r_ana) begin
                        if (!r_ch) r_ml <= m_y;
                        else if (m_max > r_peak[r_band[BIW-1:0]])
                            r_peak[r_band[BIW-1:0]] <= m_max;
                    end else if (!r_ch) begin
                        r_l <= r_y;
                    end else begin
                        r_r <= r_y;
                    end
                    r_ch <= ~r_ch;
                    if (r_ch) begin
                        if (final_f) begin
                            r_ovalid   <= 1'b1;
                            r_okind    <= 1'b0;
                            r_oleft    <= clamp24(r_l);
                            r_oright   <= clamp24(r_y);
                            r_oband    <= 4'd0;
                            r_olevel   <= 31'd0;
                            r_olast    <= ~r_eob;
                            r_rep_pend <= r_eob;
                            r_band     <= '0;
                            r_state    <= ST_OUT;
                        end else if (r_ana) begin
                            r_ana <= 1'b0;
                        end else begin
                            r_band <= r_band + 1'b1;
                            r_ana  <= (r_band != BCW'(NUM_BANDS - 1));
                        end
                    end
                end
                ST_OUT: begin
                    if (i_ready) begin
                        if (r_rep_pend) begin
                            r_okind    <= 1'b1;
                            r_oleft    <= 24'sd0;
                            r_oright   <= 24'sd0;
                            r_oband    <= 4'(r_band);
                            r_olevel   <= r_peak[r_band[BIW-1:0]];
                            r_olast    <= last_band;
                            r_peak[r_band[BIW-1:0]] <= '0;
                            r_band     <= r_band + 1'b1;
                            r_rep_pend <= ~last_band;
                        end else begin
                            r_ovalid <= 1'b0;
                            r_state  <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_cfg_ready  = 1'b1;
    assign o_ready      = (r_state == ST_IDLE);
    assign o_valid      = r_ovalid;
    assign o_kind       = r_okind;
    assign o_left_out   = r_oleft;
    assign o_right_out  = r_oright;
    assign o_band_index = r_oband;
    assign o_band_level = r_olevel;
    assign o_last       = r_olast;

endmodule

// File: hw/rtl/sbeq_checker.sv
// Port-level checks for the stereo biquad equaliser, bound to the top level
`timescale 1ns / 1ps
module sbeq_checker import sbeq_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic [1:0]         i_opcode,
    input logic               o_valid,
    input logic               i_ready,
    input logic               o_kind,
    input logic signed [23:0] o_left_out,
    input logic signed [23:0] o_right_out,
    input logic [3:0]         o_band_index,
    input logic [30:0]        o_band_level
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output word dropped before accept");

    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken while output pending");

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_opcode == OP_SAMPLE |=> !o_ready && !o_valid)
        else $error("sample word not held busy");

    a_report_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> o_left_out == 24'sd0 && o_right_out == 24'sd0)
        else $error("report word carries sample data");

    a_pair_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_kind |-> o_band_index == 4'd0 && o_band_level == 31'd0)
        else $error("pair word carries band data");

endmodule

bind stereo_biquad_eq_with_band_meters_top sbeq_checker u_sbeq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .i_opcode     (i_opcode),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_kind       (o_kind),
    .o_left_out   (o_left_out),
    .o_right_out  (o_right_out),
    .o_band_index (o_band_index),
    .o_band_level (o_band_level)
);
